### hdl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit partition allocator package
// Field widths, action codes and status codes shared by the interfaces and
// the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfpa_pkg;

    // Widths of the words on the request and response channels.
    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 16;
    localparam int SEL_W    = 4;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [FIELD_W-1:0]  field_t;
    typedef logic [SEL_W-1:0]    sel_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request actions.
    localparam action_t ACT_ADD   = 2'd0;
    localparam action_t ACT_ALLOC = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    // Response status codes.
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_NOFIT  = 2'd1;
    localparam status_t ST_FULL   = 2'd2;
    localparam status_t ST_ABSENT = 2'd3;

endpackage

`default_nettype wire

### hdl/bfpa_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel that carries one request word: action, size and entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfpa_req_if;
    import bfpa_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    field_t  size_value;
    sel_t    entry_select;

    modport source (output valid, output action, output size_value,
                    output entry_select, input ready);
    modport sink   (input valid, input action, input size_value,
                    input entry_select, output ready);
endinterface

`default_nettype wire

### hdl/bfpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel that carries one response word describing an entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfpa_rsp_if;
    import bfpa_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    sel_t    entry_index;
    field_t  entry_size;
    field_t  used_size;
    logic    entry_free;

    modport source (output valid, output status, output entry_index,
                    output entry_size, output used_size, output entry_free,
                    input ready);
    modport sink   (input valid, input status, input entry_index,
                    input entry_size, input used_size, input entry_free,
                    output ready);
endinterface

`default_nettype wire

### hdl/bfpa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit partition allocator
// Table of fixed partitions with add, best-fit allocate and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel and each one yields exactly one word
//   on the rsp channel, in order. An add appends a free partition, an
//   allocate claims the smallest free partition that fits (the later entry
//   wins among equal sizes), and a read reports one entry.
//   The block works on one request at a time and lowers req.ready while busy.
//   An add, an invalid action or a read of an absent entry goes straight to
//   the emit state; a read of a present entry first waits for the RAM read
//   data, and an allocate scans every partition in the table, then drains
//   and commits, or commits at once on an empty table. The allocate scan
//   reads one table entry per cycle through the single RAM read port and
//   one comparator pair.
//   A new request is taken in the cycle after its predecessor's response
//   enters the output register, so a waiting response does not stop it.
//   If the receiver stalls, the response holds in the output register and
//   a finished follow-on request waits until that register is taken.
//   Reset empties the table and the output register; the table RAM needs no
//   clearing pass because only entries already added are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_partition_allocator #(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfpa_req_if.sink    req,
    bfpa_rsp_if.source  rsp
);
    import bfpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PARTITIONS);
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int CMP_W  = (CNT_W > SEL_W) ? CNT_W : SEL_W;
    localparam int WORD_W = 2 * SIZE_BITS + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    // Width conversions between the channel fields and the table.
    function automatic logic [SIZE_BITS-1:0] field_to_size(field_t f);
        logic [FIELD_W+SIZE_BITS-1:0] t;
        t = {{SIZE_BITS{1'b0}}, f};
        return t[SIZE_BITS-1:0];
    endfunction

    function automatic field_t size_to_field(logic [SIZE_BITS-1:0] s);
        logic [FIELD_W+SIZE_BITS-1:0] t;
        t = {{FIELD_W{1'b0}}, s};
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] sel_to_idx(sel_t s);
        logic [IDX_W+SEL_W-1:0] t;
        t = {{IDX_W{1'b0}}, s};
        return t[IDX_W-1:0];
    endfunction

    function automatic sel_t idx_to_sel(logic [IDX_W-1:0] i);
        logic [IDX_W+SEL_W-1:0] t;
        t = {{SEL_W{1'b0}}, i};
        return t[SEL_W-1:0];
    endfunction

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SIZE_BITS-1:0] val_reg, val_next;
    sel_t                 sel_reg, sel_next;
    logic [CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;

    // Finished result waiting for the output register.
    status_t              res_status_reg, res_status_next;
    sel_t                 res_index_reg, res_index_next;
    field_t               res_size_reg, res_size_next;
    field_t               res_used_reg, res_used_next;
    logic                 res_free_reg, res_free_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    sel_t                 out_index_reg, out_index_next;
    field_t               out_size_reg, out_size_next;
    field_t               out_used_reg, out_used_next;
    logic                 out_free_reg, out_free_next;

    // Table RAM: {free, used size, partition size} per entry.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic [SIZE_BITS-1:0] rd_size;
    logic [SIZE_BITS-1:0] rd_used;
    logic                 rd_free;
    logic                 accept;
    logic                 hit;
    logic                 better;
    logic                 full;
    logic                 sel_present;
    logic                 out_free_slot;
    logic [SIZE_BITS-1:0] in_val;

    bfpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PARTITIONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_size = ram_rdata[SIZE_BITS-1:0];
    assign rd_used = ram_rdata[2*SIZE_BITS-1:SIZE_BITS];
    assign rd_free = ram_rdata[2*SIZE_BITS];

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign in_val        = field_to_size(req.size_value);
    assign full          = (count_reg == CNT_W'(MAX_PARTITIONS));
    assign sel_present   = (CMP_W'(req.entry_select) < CMP_W'(count_reg));
    assign out_free_slot = !out_valid_reg || rsp.ready;

    // Shared comparator pair: fits the request, and is no larger than the best.
    assign hit    = pend_reg && rd_free && (rd_size >= val_reg);
    assign better = !found_reg || (rd_size <= best_size_reg);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        val_next        = val_reg;
        sel_next        = sel_reg;
        scan_addr_next  = scan_addr_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_size_next   = res_size_reg;
        res_used_next   = res_used_reg;
        res_free_next   = res_free_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_size_next   = out_size_reg;
        out_used_next   = out_used_reg;
        out_free_next   = out_free_reg;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = {1'b0, val_reg, best_size_reg};
        ram_raddr       = scan_addr_reg[IDX_W-1:0];

        // Track the best candidate for the word read in the previous cycle.
        if (hit && better)
        begin
            found_next     = 1'b1;
            best_idx_next  = pend_idx_reg;
            best_size_next = rd_size;
        end

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = sel_to_idx(req.entry_select);
                if (accept)
                begin
                    val_next        = in_val;
                    sel_next        = req.entry_select;
                    res_status_next = ST_ABSENT;
                    res_index_next  = '0;
                    res_size_next   = '0;
                    res_used_next   = '0;
                    res_free_next   = 1'b0;
                    state_next      = S_EMIT;
                    case (req.action)
                        ACT_ADD:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = count_reg[IDX_W-1:0];
                                ram_wdata       = {1'b1, {SIZE_BITS{1'b0}}, in_val};
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                                res_index_next  = idx_to_sel(count_reg[IDX_W-1:0]);
                                res_size_next   = size_to_field(in_val);
                                res_free_next   = 1'b1;
                            end
                        end
                        ACT_ALLOC:
                        begin
                            found_next     = 1'b0;
                            scan_addr_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = S_COMMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_READ:
                        begin
                            if (sel_present)
                            begin
                                state_next = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Issue one table read per cycle.
            S_SCAN:
            begin
                pend_next      = 1'b1;
                pend_idx_next  = scan_addr_reg[IDX_W-1:0];
                scan_addr_next = scan_addr_reg + CNT_W'(1);
                if ((scan_addr_reg + CNT_W'(1)) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            // Compare the last word read.
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end

            // Claim the winner, or report no fit.
            S_COMMIT:
            begin
                if (found_reg)
                begin
                    ram_we          = 1'b1;
                    res_status_next = ST_OK;
                    res_index_next  = idx_to_sel(best_idx_reg);
                    res_size_next   = size_to_field(best_size_reg);
                    res_used_next   = size_to_field(val_reg);
                    res_free_next   = 1'b0;
                end
                else
                begin
                    res_status_next = ST_NOFIT;
                end
                state_next = S_EMIT;
            end

            // Read data for a present entry.
            S_RDWAIT:
            begin
                res_status_next = ST_OK;
                res_index_next  = sel_reg;
                res_size_next   = size_to_field(rd_size);
                res_used_next   = size_to_field(rd_used);
                res_free_next   = rd_free;
                state_next      = S_EMIT;
            end

            // Move the result into the output register once it is free.
            S_EMIT:
            begin
                if (out_free_slot)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_size_next   = res_size_reg;
                    out_used_next   = res_used_reg;
                    out_free_next   = res_free_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        sel_reg        <= sel_next;
        scan_addr_reg  <= scan_addr_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_size_reg  <= best_size_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_size_reg   <= res_size_next;
        res_used_reg   <= res_used_next;
        res_free_reg   <= res_free_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_size_reg   <= out_size_next;
        out_used_reg   <= out_used_next;
        out_free_reg   <= out_free_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.entry_size  = out_size_reg;
    assign rsp.used_size   = out_used_reg;
    assign rsp.entry_free  = out_free_reg;

    // The table never holds more partitions than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTITIONS))
    else $error("partition count exceeds table depth");

    // An add to a table with room grows the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_ADD && !full)
            |=> count_reg == $past(count_reg) + CNT_W'(1))
    else $error("add did not grow the partition count");

    // A compared word always belongs to an entry in the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CNT_W'(pend_idx_reg) < count_reg))
    else $error("scan compared an entry beyond the table");

    // A result leaving the sequencer shows up on the response channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free_slot)
            |=> (rsp.valid && state_reg == S_IDLE))
    else $error("finished result not presented");

endmodule

`default_nettype wire
